// ----- rtl/sdtq_pkg.sv -----
// Package for the sorted delivery timer queue: field widths, codes and the
// transaction and cell structs. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sdtq_pkg;

  localparam int TIME_BITS    = 20;
  localparam int TAG_BITS     = 16;
  localparam int CAPACITY_DEF = 16;
  localparam int OCC_OUT_BITS = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_REJECTED = 2'd1;
  localparam logic [1:0] STATUS_TICK     = 2'd2;

  typedef struct packed {
    logic                 opcode;
    logic [TAG_BITS-1:0]  item_tag;
    logic [TIME_BITS-1:0] delay_seconds;
    logic [TIME_BITS-1:0] elapsed_seconds;
  } cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    delivered_valid;
    logic [TAG_BITS-1:0]     delivered_tag;
    logic                    last_result;
    logic [OCC_OUT_BITS-1:0] occupancy_after;
  } result_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_TICK   = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_t;

  // Broadcast to every cell in the chain.
  typedef struct packed {
    cell_op_t             op;
    logic [TAG_BITS-1:0]  tag;
    logic [TIME_BITS-1:0] delay;
    logic [TIME_BITS-1:0] elapsed;
  } cell_bus_t;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] time_left;
    logic [TAG_BITS-1:0]  tag;
  } cell_data_t;

endpackage

// ----- rtl/sdtq_cell.sv -----
// One queue cell: holds one entry and trades it with its neighbors.
// Depends on sdtq_pkg.
`timescale 1ns / 1ps

module sdtq_cell (
  input  logic               clk,
  input  logic               rst,
  input  sdtq_pkg::cell_bus_t  bus,
  input  sdtq_pkg::cell_data_t prev_data,
  input  sdtq_pkg::cell_data_t next_data,
  input  logic               keep_in,
  output logic               keep_out,
  output sdtq_pkg::cell_data_t data
);
  import sdtq_pkg::*;

  cell_data_t data_next;

  // The entry stays ahead of a new item when its time is not larger.
  assign keep_out = data.valid && (data.time_left <= bus.delay);

  always_comb begin
    data_next = data;
    case (bus.op)
      CELL_INSERT: begin
        if (!keep_out) begin
          if (keep_in) begin
            data_next.valid     = 1'b1;
            data_next.time_left = bus.delay;
            data_next.tag       = bus.tag;
          end else begin
            data_next = prev_data;
          end
        end
      end
      CELL_TICK: begin
        data_next.time_left = (data.time_left > bus.elapsed) ?
                              data.time_left - bus.elapsed : '0;
      end
      CELL_SHIFT: data_next = next_data;
      default:    data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data.time_left <= data_next.time_left;
    data.tag       <= data_next.tag;
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid <= data_next.valid;
    end
  end

endmodule

// ----- rtl/sorted_delivery_timer_queue_core.sv -----
// Top level of the sorted delivery timer queue: a chain of sdtq_cell entries
// plus the command sequencer and the registered result port. Depends on sdtq_pkg.
`timescale 1ns / 1ps

//  Channel   Handshake            Payload    Direction
//  command   start & !busy        cmd        in
//  result    done (one cycle)     result     out
//
// An insert's single result appears the cycle after it is accepted, and busy
// stays low, so inserts may follow each other every cycle. A tick first
// subtracts the elapsed time in every cell, then reports each delivered tag
// in turn as the head cell shifts out, or gives a single empty report when
// no entry is due. Reset is synchronous on rst and clears the cell valid
// bits, the occupancy count and the sequencer.
// The receiver cannot stall; each result is on the port for exactly one cycle.

module sorted_delivery_timer_queue_core #(
  parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sdtq_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done,
  output sdtq_pkg::result_t result
);
  import sdtq_pkg::*;

  localparam int OCC_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state;
  logic [OCC_W-1:0]  occ;
  cell_bus_t         bus;
  cell_data_t        cells [CAPACITY];
  cell_data_t        prev_of [CAPACITY];
  cell_data_t        next_of [CAPACITY];
  logic              keep [CAPACITY];
  logic              keep_in_of [CAPACITY];
  logic [CAPACITY-1:0] due_vec;
  logic [OCC_W-1:0]  due_cnt;
  logic [OCC_W-1:0]  occ_after;
  logic              full;
  logic              accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = cells[CAPACITY-1].valid;

  // The chain of cells. Cell 0 sees a neighbor that always keeps its place,
  // so a new item lands there when nothing held goes in front of it.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_of[i]    = '0;
      assign keep_in_of[i] = 1'b1;
    end else begin : g_body
      assign prev_of[i]    = cells[i-1];
      assign keep_in_of[i] = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_of[i] = '0;
    end else begin : g_mid
      assign next_of[i] = cells[i+1];
    end

    // Entries with zero time left form a prefix of the queue after a tick.
    assign due_vec[i] = cells[i].valid && (cells[i].time_left == '0);

    sdtq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bus       (bus),
      .prev_data (prev_of[i]),
      .next_data (next_of[i]),
      .keep_in   (keep_in_of[i]),
      .keep_out  (keep[i]),
      .data      (cells[i])
    );
  end

  // Each delivery removes one due entry and one from the count, so this
  // difference already equals the occupancy after all removals.
  assign due_cnt   = OCC_W'($countones(due_vec));
  assign occ_after = occ - due_cnt;

  // Command broadcast to the cells.
  always_comb begin
    bus.tag     = cmd.item_tag;
    bus.delay   = cmd.delay_seconds;
    bus.elapsed = cmd.elapsed_seconds;
    bus.op      = CELL_HOLD;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (cmd.opcode == OP_TICK) begin
            bus.op = CELL_TICK;
          end else if (!full) begin
            bus.op = CELL_INSERT;
          end
        end
      end
      ST_DRAIN: begin
        if (due_vec[0]) begin
          bus.op = CELL_SHIFT;
        end
      end
      default: bus.op = CELL_HOLD;
    endcase
  end

  // Sequencer, occupancy count and the registered result transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      occ   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (cmd.opcode == OP_TICK) begin
              state <= ST_DRAIN;
            end else begin
              done                   <= 1'b1;
              result.delivered_valid <= 1'b0;
              result.delivered_tag   <= '0;
              result.last_result     <= 1'b1;
              if (full) begin
                result.status          <= STATUS_REJECTED;
                result.occupancy_after <= OCC_OUT_BITS'(occ);
              end else begin
                result.status          <= STATUS_ACCEPTED;
                result.occupancy_after <= OCC_OUT_BITS'(occ + 1'b1);
                occ                    <= occ + 1'b1;
              end
            end
          end
        end
        ST_DRAIN: begin
          done                   <= 1'b1;
          result.status          <= STATUS_TICK;
          result.occupancy_after <= OCC_OUT_BITS'(occ_after);
          if (due_vec[0]) begin
            // The head cell is due: hand out its tag and shift the chain.
            result.delivered_valid <= 1'b1;
            result.delivered_tag   <= cells[0].tag;
            result.last_result     <= !due_vec[1];
            occ                    <= occ - 1'b1;
            if (!due_vec[1]) begin
              state <= ST_IDLE;
            end
          end else begin
            // Nothing reached zero: a single empty report.
            result.delivered_valid <= 1'b0;
            result.delivered_tag   <= '0;
            result.last_result     <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sdtq_checker.sv -----
// Port-level checker for the sorted delivery timer queue, bound to the top level.
// Depends on sdtq_pkg and sorted_delivery_timer_queue_core.
`timescale 1ns / 1ps

module sdtq_checker #(
  parameter int CAPACITY = sdtq_pkg::CAPACITY_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input sdtq_pkg::cmd_t    cmd,
  input logic              busy,
  input logic              done,
  input sdtq_pkg::result_t result
);
  import sdtq_pkg::*;

  // A result that is not the last of its transaction is followed by another.
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    done && !result.last_result |-> busy ##1 done)
    else $error("non-last result not followed by another result");

  // Insert results are single and carry no delivered item.
  a_insert_single: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != STATUS_TICK) |-> result.last_result
      && !result.delivered_valid)
    else $error("insert result malformed");

  // An accepted tick holds off the command side in the next cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (cmd.opcode == OP_TICK) |=> busy && !done)
    else $error("tick did not enter its drain phase");

  // Occupancy never exceeds the capacity.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.occupancy_after <= CAPACITY))
    else $error("occupancy beyond capacity");

endmodule

bind sorted_delivery_timer_queue_core sdtq_checker #(.CAPACITY(CAPACITY)) u_sdtq_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/tb_sorted_delivery_timer_queue_core.sv -----
// Self-checking testbench for sorted_delivery_timer_queue_core: a directed run and
// then random insert/tick traffic, checked against a cycle-free queue predictor.
// Depends on sdtq_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_sorted_delivery_timer_queue_core;
  import sdtq_pkg::*;

  // The watchdog limit is counted in cycles with no accepted transaction. The
  // slowest correct tick keeps the command side busy while it delivers every
  // entry of a full queue, and driver gaps are short, so this leaves a wide margin.
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 2 * CAPACITY_DEF;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  sorted_delivery_timer_queue_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Commands waiting to be sent, filled once by the stimulus block. The driver
  // never pops; accepted_cmds points at the next command to offer.
  cmd_t    pending_cmds[$];
  // Reports the queue must still produce, oldest first.
  result_t expected_reports[$];

  // Predicted contents of the timer queue, kept sorted by time left.
  logic [TIME_BITS-1:0] held_time[CAPACITY_DEF];
  logic [TAG_BITS-1:0]  held_tag[CAPACITY_DEF];
  int                   held_count = 0;

  int accepted_cmds = 0;
  int offered_idx   = -1;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  bit progress;

  function automatic result_t make_report(input logic [1:0] st, input logic dv,
                                          input logic [TAG_BITS-1:0] tg,
                                          input logic lst, input int occ);
    result_t r;
    r.status          = st;
    r.delivered_valid = dv;
    r.delivered_tag   = tg;
    r.last_result     = lst;
    r.occupancy_after = OCC_OUT_BITS'(occ);
    return r;
  endfunction

  // Applies one accepted command to the predicted queue and queues up the
  // reports it must cause.
  task automatic predict_deliveries(input cmd_t c);
    int pos;
    int due;
    int i;
    if (c.opcode == OP_INSERT) begin
      if (held_count >= CAPACITY_DEF) begin
        expected_reports.push_back(make_report(STATUS_REJECTED, 1'b0, '0, 1'b1, held_count));
      end else begin
        // A new item goes behind every entry with an equal or smaller time, so
        // ties keep their arrival order.
        pos = 0;
        while (pos < held_count && held_time[pos] <= c.delay_seconds) pos++;
        for (i = held_count; i > pos; i--) begin
          held_time[i] = held_time[i-1];
          held_tag[i]  = held_tag[i-1];
        end
        held_time[pos] = c.delay_seconds;
        held_tag[pos]  = c.item_tag;
        held_count++;
        expected_reports.push_back(make_report(STATUS_ACCEPTED, 1'b0, '0, 1'b1, held_count));
      end
    end else begin
      // Saturating subtract; the queue stays sorted, so every zero entry is at
      // the head.
      for (i = 0; i < held_count; i++) begin
        held_time[i] = (held_time[i] > c.elapsed_seconds) ?
                       held_time[i] - c.elapsed_seconds : '0;
      end
      due = 0;
      while (due < held_count && held_time[due] == '0) due++;
      if (due == 0) begin
        expected_reports.push_back(make_report(STATUS_TICK, 1'b0, '0, 1'b1, held_count));
      end else begin
        for (i = 0; i < due; i++) begin
          expected_reports.push_back(make_report(STATUS_TICK, 1'b1, held_tag[i],
                                                 i == due - 1, held_count - due));
        end
        for (i = 0; i + due < held_count; i++) begin
          held_time[i] = held_time[i+due];
          held_tag[i]  = held_tag[i+due];
        end
        held_count -= due;
      end
    end
  endtask

  function automatic void add_cmd(input logic op, input logic [TAG_BITS-1:0] tg,
                                  input logic [TIME_BITS-1:0] dly,
                                  input logic [TIME_BITS-1:0] ela);
    cmd_t c;
    c.opcode          = op;
    c.item_tag        = tg;
    c.delay_seconds   = dly;
    c.elapsed_seconds = ela;
    pending_cmds.push_back(c);
  endfunction

  // Mostly small times so that ticks actually deliver, with zero and the full
  // range mixed in so that every bit toggles and saturation is reached.
  function automatic logic [TIME_BITS-1:0] rand_time();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return TIME_BITS'($urandom);
      default: return TIME_BITS'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic void add_insert(input logic [TIME_BITS-1:0] dly);
    add_cmd(OP_INSERT, TAG_BITS'($urandom), dly, TIME_BITS'($urandom));
  endfunction

  function automatic void add_tick(input logic [TIME_BITS-1:0] ela);
    add_cmd(OP_TICK, TAG_BITS'($urandom), TIME_BITS'($urandom), ela);
  endfunction

  // Driver: changes inputs on the falling edge. A command that is on the port
  // and not yet accepted stays there unchanged. Idling is random at about 16
  // percent, except for a calm stretch in the middle of the run.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && accepted_cmds == offered_idx) begin
      // Still waiting for busy to drop; keep the command as it is.
    end else if (accepted_cmds < pending_cmds.size() &&
                 ((accepted_cmds >= 180 && accepted_cmds < 300) ||
                  $urandom_range(0, 99) >= 16)) begin
      start       <= 1'b1;
      cmd         <= pending_cmds[accepted_cmds];
      offered_idx = accepted_cmds;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: samples on the rising edge. Results are checked before the
  // accepted command is predicted, so a report always meets the expectations
  // that were already waiting for it.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      progress = 1'b0;
      if (done) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: status %0d tag %0h occupancy %0d",
                 result.status, result.delivered_tag, result.occupancy_after);
          mismatches++;
        end else begin
          if (result.status !== expected_reports[0].status) begin
            $error("status: expected %0d, got %0d",
                   expected_reports[0].status, result.status);
            mismatches++;
          end
          if (result.delivered_valid !== expected_reports[0].delivered_valid) begin
            $error("delivered_valid: expected %0d, got %0d",
                   expected_reports[0].delivered_valid, result.delivered_valid);
            mismatches++;
          end
          if (result.delivered_tag !== expected_reports[0].delivered_tag) begin
            $error("delivered_tag: expected %0h, got %0h",
                   expected_reports[0].delivered_tag, result.delivered_tag);
            mismatches++;
          end
          if (result.last_result !== expected_reports[0].last_result) begin
            $error("last_result: expected %0d, got %0d",
                   expected_reports[0].last_result, result.last_result);
            mismatches++;
          end
          if (result.occupancy_after !== expected_reports[0].occupancy_after) begin
            $error("occupancy_after: expected %0d, got %0d",
                   expected_reports[0].occupancy_after, result.occupancy_after);
            mismatches++;
          end
          void'(expected_reports.pop_front());
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        predict_deliveries(pending_cmds[accepted_cmds]);
        accepted_cmds++;
      end
      quiet_cycles = progress ? 0 : quiet_cycles + 1;
    end
  end

  // Watchdog: ends the run if the block stops moving.
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_sorted_delivery_timer_queue_core NOT OK");
    $finish;
  end

  initial begin
    int burst;
    int n;
    int stop_at;

    // Directed part. A tick on an empty queue gives one empty report.
    add_tick('0);
    // Extremes of tag and delay, a zero-delay item, and two equal delays that
    // must come out in arrival order.
    add_cmd(OP_INSERT, '0, '0, '1);
    add_cmd(OP_INSERT, '1, '1, '0);
    add_cmd(OP_INSERT, 16'h1234, 20'd5, '0);
    add_cmd(OP_INSERT, 16'h1235, 20'd5, '0);
    // A zero-elapsed tick still delivers the zero-delay item.
    add_cmd(OP_TICK, '1, '1, '0);
    // Nothing due yet, then the two equal items together.
    add_cmd(OP_TICK, '0, '0, 20'd4);
    add_cmd(OP_TICK, '0, '0, 20'd1);
    // The full-range elapsed value saturates the largest time to zero.
    add_cmd(OP_TICK, '0, '0, '1);
    // Fill the queue, push one more that must be rejected, then empty it with
    // a single tick that delivers every entry.
    for (int i = 0; i < CAPACITY_DEF + 1; i++) begin
      add_cmd(OP_INSERT, TAG_BITS'(16'hA000 + i), TIME_BITS'(CAPACITY_DEF - i), '0);
    end
    add_cmd(OP_TICK, '0, '0, '1);

    // Random part: bursts of inserts followed by a few ticks. Some bursts are
    // long enough to fill the queue and hit the rejection path.
    stop_at = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < stop_at) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(10, CAPACITY_DEF + 3)
                                          : $urandom_range(0, 6);
      for (int i = 0; i < burst; i++) add_insert(rand_time());
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) add_tick(rand_time());
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (accepted_cmds < pending_cmds.size()) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
    // Give a stray report time to show up after the last expected one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_sorted_delivery_timer_queue_core OK");
    end else begin
      $display("tb_sorted_delivery_timer_queue_core NOT OK");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sdtq_pkg.sv
rtl/sdtq_cell.sv
rtl/sorted_delivery_timer_queue_core.sv
rtl/sdtq_checker.sv
tb/tb_sorted_delivery_timer_queue_core.sv
